// ----- rtl/qla_pkg.sv -----
// Shared types and constants for the tabular Q-learning agent.
// Used by the shared multiplier, the top level, the checker and the testbench.
package qla_pkg;

   // Shared multiplier operand and product widths (signed)
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Table entry width
   localparam int VALUE_W = 32;

   // Epsilon: one and its floor (0.1 rounded) in Q1.16
   localparam int EPS_W = 17;
   localparam logic [EPS_W-1:0] EPS_ONE   = 17'd65536;
   localparam logic [EPS_W-1:0] EPS_FLOOR = 17'd6554;

   // Item kinds
   localparam logic [1:0] KIND_CHOOSE = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_DECAY  = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_LEARNING_RATE   = 3'd0;
   localparam logic [2:0] CSR_DISCOUNT        = 3'd1;
   localparam logic [2:0] CSR_EPSILON_INITIAL = 3'd2;
   localparam logic [2:0] CSR_EPSILON_DECAY   = 3'd3;
   localparam logic [2:0] CSR_ALTITUDE_SCALE  = 3'd4;
   localparam logic [2:0] CSR_VELOCITY_MIN    = 3'd5;
   localparam logic [2:0] CSR_VELOCITY_SCALE  = 3'd6;
   localparam logic [2:0] CSR_MAX_THRUST      = 3'd7;

   // Operands handed to the shared multiplier
   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_op_type;

endpackage

// ----- rtl/qla_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module qla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/qla_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on qla_pkg for operand and product widths.
module qla_mul (
   input  logic                              clock,
   input  qla_pkg::mul_op_type               op,
   output logic signed [qla_pkg::MUL_P_W-1:0] product
);
   import qla_pkg::*;

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   // full-width signed product
   assign product_in = MUL_P_W'(op.a) * MUL_P_W'(op.b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- rtl/tabular_q_learning_agent.sv -----
// Tabular Q-learning / SARSA agent with epsilon-greedy action choice.
// Channels: req_ (items in: tdata payload, tuser kind and mode flags), rsp_ (one
// result item per input item), csr_ (register writes, always ready).
// After reset the block sweeps the value table to zero, one entry per cycle,
// all ALT_BUCKETS*VEL_BUCKETS*ACTIONS entries (2048 by default); req_tready stays low
// during the sweep. Configuration writes are taken at any time.
// One item is worked at a time by a sequencer around one shared multiplier and
// the single-read-port table RAM. Steps per item kind:
//   decay: epsilon times epsilon_decay, floored at 0.1; unknown kind: straight to result;
//   choose: explore, or bucket the state and scan its row for the maximum; then thrust;
//   update: bucket both states, row maximum or SARSA entry, discount, learn, write back.
// The row maximum reads one table entry per cycle.
// The sequencer returns to idle as the result is loaded, so a new item is taken
// only after the previous one has loaded its result.
// req_tready is high only while the sequencer is idle. A finished result sits
// in the output register; the next item may be accepted meanwhile and holds at
// its last step until rsp_tready frees the output register.
// Reset loads the control and configuration registers to their defaults and epsilon to one.
module tabular_q_learning_agent #(
   parameter int ALT_BUCKETS = 16,
   parameter int VEL_BUCKETS = 16,
   parameter int ACTIONS     = 8
) (
   input  logic         clock,
   input  logic         reset,
   // current_altitude, current_velocity, action, next_altitude, next_velocity,
   // next_action, reward, random_draw, random_action; zero fill to 192
   input  logic [191:0] req_tdata,
   // kind[1:0], td_mode[2], greedy_only[3]
   input  logic [3:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // chosen_action, explored, thrust, new_q, epsilon_now; zero fill to 72
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import qla_pkg::*;

   localparam int DEPTH  = ALT_BUCKETS * VEL_BUCKETS * ACTIONS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(ALT_BUCKETS * VEL_BUCKETS);
   localparam int ALT_W  = $clog2(ALT_BUCKETS);
   localparam int VEL_W  = $clog2(VEL_BUCKETS);
   localparam int ACT_W  = $clog2(ACTIONS);
   // thrust divide by ACTIONS-1 as multiply by rounded-up reciprocal
   localparam int THR_SHIFT = 22;
   localparam int THR_RECIP = ((1 << THR_SHIFT) + ACTIONS - 2) / (ACTIONS - 1);

   // sequencer states
   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ALT      = 5'd2;
   localparam logic [4:0] S_VEL      = 5'd3;
   localparam logic [4:0] S_ROW      = 5'd4;
   localparam logic [4:0] S_SCAN     = 5'd5;
   localparam logic [4:0] S_SCAN_END = 5'd6;
   localparam logic [4:0] S_NRD      = 5'd7;
   localparam logic [4:0] S_NDAT     = 5'd8;
   localparam logic [4:0] S_QRD      = 5'd9;
   localparam logic [4:0] S_QDAT     = 5'd10;
   localparam logic [4:0] S_LR       = 5'd11;
   localparam logic [4:0] S_WB       = 5'd12;
   localparam logic [4:0] S_THR1     = 5'd13;
   localparam logic [4:0] S_THR2     = 5'd14;
   localparam logic [4:0] S_THR3     = 5'd15;
   localparam logic [4:0] S_EPS1     = 5'd16;
   localparam logic [4:0] S_EPS2     = 5'd17;
   localparam logic [4:0] S_DONE     = 5'd18;

   // control registers
   logic [4:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic              rdv_ff, rdv_in;

   // configuration registers
   logic [15:0]        lr_ff, disc_ff, decay_ff, max_thr_ff;
   logic [23:0]        alt_scale_ff, vel_scale_ff;
   logic signed [31:0] vel_min_ff;

   // payload registers
   logic [191:0]       req_data_ff, req_data_in;
   logic [3:0]         req_user_ff, req_user_in;
   logic               which_ff, which_in;
   logic [ALT_W-1:0]   alt_idx_ff, alt_idx_in;
   logic [ADDR_W-1:0]  cur_base_ff, cur_base_in, nxt_base_ff, nxt_base_in;
   logic [ACT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [ACT_W-1:0]   rd_act_ff, rd_act_in;
   logic signed [31:0] best_val_ff, best_val_in;
   logic [ACT_W-1:0]   best_act_ff, best_act_in;
   logic signed [31:0] q_ff, q_in;
   logic signed [33:0] target_ff, target_in;
   logic [2:0]         chosen_ff, chosen_in;
   logic               explored_ff, explored_in;
   logic [15:0]        thrust_ff, thrust_in;
   logic [31:0]        newq_ff, newq_in;
   logic [71:0]        rsp_data_ff, rsp_data_in;

   // request fields
   logic [1:0]         f_kind;
   logic signed [31:0] f_cur_alt, f_cur_vel, f_nxt_alt, f_nxt_vel, f_reward;
   logic [2:0]         f_action, f_next_action, f_rand_action;
   logic               f_td_mode, f_greedy;
   logic [15:0]        f_draw;

   // shared units
   mul_op_type                 mul_op;
   logic signed [MUL_P_W-1:0]  prod;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
   logic [VALUE_W-1:0]         ram_wdata, ram_rdata;

   // temporaries
   logic signed [31:0] alt_src, vel_src;
   logic signed [33:0] vel_d;
   logic [VEL_W-1:0]   vel_idx;
   logic [ROW_W-1:0]   row;
   logic [ADDR_W-1:0]  row_base;
   logic signed [35:0] diff;
   logic signed [45:0] nv;
   logic [16:0]        eps_prod;
   logic               rsp_free;

   // action index modulo ACTIONS, by repeated subtraction
   function automatic logic [ACT_W-1:0] act_mod(input logic [2:0] v);
      logic [3:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 4; i++) begin
         if (r >= 4'(ACTIONS)) begin
            r = r - 4'(ACTIONS);
         end
      end
      return r[ACT_W-1:0];
   endfunction

   assign f_kind        = req_user_ff[1:0];
   assign f_td_mode     = req_user_ff[2];
   assign f_greedy      = req_user_ff[3];
   assign f_cur_alt     = req_data_ff[31:0];
   assign f_cur_vel     = req_data_ff[63:32];
   assign f_action      = req_data_ff[66:64];
   assign f_nxt_alt     = req_data_ff[98:67];
   assign f_nxt_vel     = req_data_ff[130:99];
   assign f_next_action = req_data_ff[133:131];
   assign f_reward      = req_data_ff[165:134];
   assign f_draw        = req_data_ff[181:166];
   assign f_rand_action = req_data_ff[184:182];

   qla_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .product (prod)
   );

   qla_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // bucket sources and index arithmetic
   assign alt_src = which_ff ? f_nxt_alt : f_cur_alt;
   assign vel_src = which_ff ? f_nxt_vel : f_cur_vel;
   assign vel_d   = 34'(vel_src) - 34'(vel_min_ff);
   assign vel_idx = (prod[60:32] > 29'(VEL_BUCKETS - 1)) ? VEL_W'(VEL_BUCKETS - 1)
                                                         : VEL_W'(prod[60:32]);
   assign row      = ROW_W'(alt_idx_ff) * ROW_W'(VEL_BUCKETS) + ROW_W'(vel_idx);
   assign row_base = ADDR_W'(row) * ADDR_W'(ACTIONS);
   assign diff     = 36'(target_ff) - 36'(q_ff);
   assign nv       = 46'(q_ff) + 46'($signed(prod[60:16]));
   assign eps_prod = prod[32:16];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      eps_in       = eps_ff;
      rdv_in       = 1'b0;
      req_data_in  = req_data_ff;
      req_user_in  = req_user_ff;
      which_in     = which_ff;
      alt_idx_in   = alt_idx_ff;
      cur_base_in  = cur_base_ff;
      nxt_base_in  = nxt_base_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_act_in    = rd_act_ff;
      best_val_in  = best_val_ff;
      best_act_in  = best_act_ff;
      q_in         = q_ff;
      target_in    = target_ff;
      chosen_in    = chosen_ff;
      explored_in  = explored_ff;
      thrust_in    = thrust_ff;
      newq_in      = newq_ff;
      rsp_data_in  = rsp_data_ff;
      mul_op.a     = '0;
      mul_op.b     = '0;
      ram_we       = 1'b0;
      ram_waddr    = clr_cnt_ff;
      ram_wdata    = '0;
      ram_raddr    = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // row scan: compare each returned entry, lowest action wins ties
      if (rdv_ff) begin
         if (rd_act_ff == '0 || $signed(ram_rdata) > best_val_ff) begin
            best_val_in = $signed(ram_rdata);
            best_act_in = rd_act_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               req_data_in = req_tdata;
               req_user_in = req_tuser;
               which_in    = 1'b0;
               chosen_in   = '0;
               explored_in = 1'b0;
               thrust_in   = '0;
               newq_in     = '0;
               case (req_tuser[1:0])
                  KIND_CHOOSE: begin
                     if (!req_tuser[3] && {1'b0, req_tdata[181:166]} < eps_ff) begin
                        chosen_in   = 3'(act_mod(req_tdata[184:182]));
                        explored_in = 1'b1;
                        state_in    = S_THR1;
                     end else begin
                        state_in = S_ALT;
                     end
                  end
                  KIND_UPDATE: state_in = S_ALT;
                  KIND_DECAY:  state_in = S_EPS1;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_ALT: begin
            mul_op.a = alt_src[31] ? '0 : MUL_A_W'(alt_src);
            mul_op.b = MUL_B_W'({1'b0, alt_scale_ff});
            state_in = S_VEL;
         end
         S_VEL: begin
            alt_idx_in = (prod[60:32] > 29'(ALT_BUCKETS - 1)) ? ALT_W'(ALT_BUCKETS - 1)
                                                              : ALT_W'(prod[60:32]);
            mul_op.a = vel_d[33] ? '0 : MUL_A_W'(vel_d);
            mul_op.b = MUL_B_W'({1'b0, vel_scale_ff});
            state_in = S_ROW;
         end
         S_ROW: begin
            scan_cnt_in = '0;
            if (!which_ff) begin
               cur_base_in = row_base;
               if (f_kind == KIND_UPDATE) begin
                  which_in = 1'b1;
                  state_in = S_ALT;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               nxt_base_in = row_base;
               state_in    = f_td_mode ? S_NRD : S_SCAN;
            end
         end
         S_SCAN: begin
            ram_raddr   = ((f_kind == KIND_CHOOSE) ? cur_base_ff : nxt_base_ff)
                          + ADDR_W'(scan_cnt_ff);
            rdv_in      = 1'b1;
            rd_act_in   = scan_cnt_ff;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == ACT_W'(ACTIONS - 1)) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = (f_kind == KIND_CHOOSE) ? S_THR1 : S_QRD;
         end
         S_NRD: begin
            ram_raddr = nxt_base_ff + ADDR_W'(act_mod(f_next_action));
            state_in  = S_NDAT;
         end
         S_NDAT: begin
            best_val_in = $signed(ram_rdata);
            state_in    = S_QRD;
         end
         S_QRD: begin
            ram_raddr = cur_base_ff + ADDR_W'(act_mod(f_action));
            mul_op.a  = MUL_A_W'(best_val_ff);
            mul_op.b  = MUL_B_W'({1'b0, disc_ff});
            state_in  = S_QDAT;
         end
         S_QDAT: begin
            q_in      = $signed(ram_rdata);
            target_in = 34'(f_reward) + 34'($signed(prod[48:16]));
            state_in  = S_LR;
         end
         S_LR: begin
            mul_op.a = diff;
            mul_op.b = MUL_B_W'({1'b0, lr_ff});
            state_in = S_WB;
         end
         S_WB: begin
            if (nv > 46'sd2147483647) begin
               newq_in = 32'h7FFF_FFFF;
            end else if (nv < -46'sd2147483648) begin
               newq_in = 32'h8000_0000;
            end else begin
               newq_in = nv[31:0];
            end
            ram_we    = 1'b1;
            ram_waddr = cur_base_ff + ADDR_W'(act_mod(f_action));
            ram_wdata = newq_in;
            state_in  = S_DONE;
         end
         S_THR1: begin
            if (!explored_ff) begin
               chosen_in = 3'(best_act_ff);
            end
            mul_op.a = MUL_A_W'({1'b0, max_thr_ff});
            mul_op.b = explored_ff ? MUL_B_W'(chosen_ff) : MUL_B_W'(best_act_ff);
            state_in = S_THR2;
         end
         S_THR2: begin
            mul_op.a = MUL_A_W'(prod[18:0]);
            mul_op.b = MUL_B_W'(THR_RECIP);
            state_in = S_THR3;
         end
         S_THR3: begin
            thrust_in = prod[THR_SHIFT+15:THR_SHIFT];
            state_in  = S_DONE;
         end
         S_EPS1: begin
            mul_op.a = MUL_A_W'(eps_ff);
            mul_op.b = MUL_B_W'({1'b0, decay_ff});
            state_in = S_EPS2;
         end
         S_EPS2: begin
            eps_in   = (eps_prod < EPS_FLOOR) ? EPS_FLOOR : eps_prod;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, eps_ff, newq_ff, thrust_ff, explored_ff, chosen_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // epsilon_initial write reloads epsilon, saturated to one
      if (csr_valid && csr_index == CSR_EPSILON_INITIAL) begin
         eps_in = (csr_data[16:0] > EPS_ONE) ? EPS_ONE : csr_data[16:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         eps_ff       <= EPS_ONE;
         rdv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         eps_ff       <= eps_in;
         rdv_ff       <= rdv_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff        <= 16'd6554;
         disc_ff      <= 16'd64225;
         decay_ff     <= 16'd65208;
         alt_scale_ff <= 24'd65536;
         vel_min_ff   <= -32'sd655360;
         vel_scale_ff <= 24'd65536;
         max_thr_ff   <= 16'd65535;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEARNING_RATE:   lr_ff        <= csr_data[15:0];
            CSR_DISCOUNT:        disc_ff      <= csr_data[15:0];
            CSR_EPSILON_INITIAL: ;  // only reloads epsilon in the sequencer
            CSR_EPSILON_DECAY:   decay_ff     <= csr_data[15:0];
            CSR_ALTITUDE_SCALE:  alt_scale_ff <= csr_data[23:0];
            CSR_VELOCITY_MIN:    vel_min_ff   <= csr_data;
            CSR_VELOCITY_SCALE:  vel_scale_ff <= csr_data[23:0];
            CSR_MAX_THRUST:      max_thr_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      req_user_ff <= req_user_in;
      which_ff    <= which_in;
      alt_idx_ff  <= alt_idx_in;
      cur_base_ff <= cur_base_in;
      nxt_base_ff <= nxt_base_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_act_ff   <= rd_act_in;
      best_val_ff <= best_val_in;
      best_act_ff <= best_act_in;
      q_ff        <= q_in;
      target_ff   <= target_in;
      chosen_ff   <= chosen_in;
      explored_ff <= explored_in;
      thrust_ff   <= thrust_in;
      newq_ff     <= newq_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- test/qla_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the tabular Q-learning agent: watches req_, rsp_ and csr_,
// keeps its own value table, epsilon and registers, and compares each result.
// Depends on qla_pkg for item kinds, register indexes and epsilon constants.
module qla_checker
   import qla_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [191:0] req_tdata,
   input  logic [3:0]   req_tuser,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           mismatch_count,
   output int           pending_count,
   output int           update_count
);

   localparam int ALT_BUCKETS = 16;
   localparam int VEL_BUCKETS = 16;
   localparam int ACTIONS     = 8;
   localparam int TABLE_SIZE  = ALT_BUCKETS * VEL_BUCKETS * ACTIONS;

   // Packed from the top bit down, so chosen_action lands in the lowest bits
   typedef struct packed {
      logic [16:0] epsilon_now;
      logic [31:0] new_q;
      logic [15:0] thrust;
      logic        explored;
      logic [2:0]  chosen_action;
   } agent_result_type;

   // Shadow registers and state
   logic [15:0]        alpha, gamma, decay_factor, thrust_max;
   logic [16:0]        eps_init, epsilon;
   logic [23:0]        alt_scale, vel_scale;
   logic signed [31:0] vel_min;
   logic signed [31:0] q_table [TABLE_SIZE];
   agent_result_type   expected_results[$];

   function automatic int alt_bucket(logic signed [31:0] alt);
      longint a;
      longint idx;
      a = alt;
      if (a < 0) a = 0;
      idx = (a * longint'(alt_scale)) >> 32;
      return (idx > ALT_BUCKETS - 1) ? ALT_BUCKETS - 1 : int'(idx);
   endfunction

   function automatic int vel_bucket(logic signed [31:0] vel);
      longint d;
      longint idx;
      d = longint'(vel) - longint'(vel_min);
      if (d < 0) d = 0;
      idx = (d * longint'(vel_scale)) >> 32;
      return (idx > VEL_BUCKETS - 1) ? VEL_BUCKETS - 1 : int'(idx);
   endfunction

   function automatic int row_of(logic signed [31:0] alt, logic signed [31:0] vel);
      return (alt_bucket(alt) * VEL_BUCKETS + vel_bucket(vel)) * ACTIONS;
   endfunction

   // Lowest action holding the row maximum
   function automatic int greedy_action(int base);
      int best;
      best = 0;
      for (int a = 1; a < ACTIONS; a++)
         if (q_table[base + a] > q_table[base + best]) best = a;
      return best;
   endfunction

   // Works out one result and advances the shadow state
   function automatic agent_result_type predict_step(logic [191:0] d, logic [3:0] u);
      agent_result_type r;
      logic [1:0]       kind;
      int               cur, nb, act;
      longint           future, target, q, nv, e;
      r = '0;
      kind = u[1:0];
      if (kind == KIND_CHOOSE) begin
         if (!u[3] && ({1'b0, d[181:166]} < epsilon)) begin
            act = int'(d[184:182]) % ACTIONS;
            r.explored = 1'b1;
         end else begin
            act = greedy_action(row_of(d[31:0], d[63:32]));
         end
         r.chosen_action = act[2:0];
         r.thrust = 16'((longint'(act) * longint'(thrust_max)) / (ACTIONS - 1));
      end else if (kind == KIND_UPDATE) begin
         cur = row_of(d[31:0], d[63:32]) + int'(d[66:64]) % ACTIONS;
         nb  = row_of(d[98:67], d[130:99]);
         if (u[2]) future = q_table[nb + int'(d[133:131]) % ACTIONS];
         else      future = q_table[nb + greedy_action(nb)];
         target = longint'($signed(d[165:134])) + ((longint'(gamma) * future) >>> 16);
         q  = q_table[cur];
         nv = q + ((longint'(alpha) * (target - q)) >>> 16);
         if (nv > 64'sd2147483647)  nv = 64'sd2147483647;
         if (nv < -64'sd2147483648) nv = -64'sd2147483648;
         q_table[cur] = 32'(nv);
         r.new_q = 32'(nv);
      end else if (kind == KIND_DECAY) begin
         e = (longint'(epsilon) * longint'(decay_factor)) >> 16;
         epsilon = (e < longint'(EPS_FLOOR)) ? EPS_FLOOR : 17'(e);
      end
      r.epsilon_now = epsilon;
      return r;
   endfunction

   always @(posedge clock) begin
      agent_result_type want, got;
      if (reset) begin
         alpha        = 16'd6554;
         gamma        = 16'd64225;
         eps_init     = EPS_ONE;
         epsilon      = EPS_ONE;
         decay_factor = 16'd65208;
         alt_scale    = 24'd65536;
         vel_min      = -32'sd655360;
         vel_scale    = 24'd65536;
         thrust_max   = 16'd65535;
         for (int i = 0; i < TABLE_SIZE; i++) q_table[i] = '0;
         expected_results.delete();
      end else begin
         // Register writes; epsilon_initial also reloads epsilon
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEARNING_RATE:   alpha = csr_data[15:0];
               CSR_DISCOUNT:        gamma = csr_data[15:0];
               CSR_EPSILON_INITIAL: begin
                  eps_init = csr_data[16:0];
                  epsilon  = (csr_data[16:0] > EPS_ONE) ? EPS_ONE : csr_data[16:0];
               end
               CSR_EPSILON_DECAY:   decay_factor = csr_data[15:0];
               CSR_ALTITUDE_SCALE:  alt_scale = csr_data[23:0];
               CSR_VELOCITY_MIN:    vel_min = csr_data;
               CSR_VELOCITY_SCALE:  vel_scale = csr_data[23:0];
               CSR_MAX_THRUST:      thrust_max = csr_data[15:0];
               default: ;
            endcase
         end
         // Accepted input item
         if (req_tvalid && req_tready) begin
            if (req_tuser[1:0] == KIND_UPDATE) update_count <= update_count + 1;
            expected_results = {expected_results, predict_step(req_tdata, req_tuser)};
         end
         // Accepted result item
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[68:0];
            if (expected_results.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("%0t: unexpected result item %h", $realtime, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (got.chosen_action !== want.chosen_action || got.explored !== want.explored
                   || got.thrust !== want.thrust || got.new_q !== want.new_q
                   || got.epsilon_now !== want.epsilon_now) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display({"%0t: mismatch act %0d/%0d expl %0d/%0d thrust %0d/%0d",
                               " q %h/%h eps %0d/%0d (exp/act)"},
                              $realtime, want.chosen_action, got.chosen_action,
                              want.explored, got.explored, want.thrust, got.thrust,
                              want.new_q, got.new_q, want.epsilon_now, got.epsilon_now);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

   initial begin
      mismatch_count = 0;
      update_count = 0;
      pending_count = 0;
   end

endmodule

// ----- test/tb_tabular_q_learning_agent.sv -----
`timescale 1ns / 1ps
// Stimulus top for the tabular Q-learning agent: clock, reset, directed and
// random items, register phases, back-pressure and verdict. Uses qla_checker.
module tb_tabular_q_learning_agent;
   import qla_pkg::*;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_PHASES = 5;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] cur_alt, cur_vel, nxt_alt, nxt_vel, reward;
      logic [2:0]  act, nxt_act, rnd_act;
      logic        td_mode, greedy;
      logic [15:0] draw;
   } agent_item_type;

   logic         clock, reset;
   logic [191:0] req_tdata;
   logic [3:0]   req_tuser;
   logic         req_tvalid, req_tready;
   logic [71:0]  rsp_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic         csr_valid, csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;
   int           mismatch_count, pending_count, update_count;
   int           sent_count, result_count;
   bit           quiet, hold_request;

   tabular_q_learning_agent DUT (.*);

   qla_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      quiet = 0;
      hold_request = 0;
      sent_count = 0;
      result_count = 0;
   end

   // Watchdog on cycles without any handshake
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_tvalid && rsp_tready) result_count++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_request = 0;
            rsp_tready <= 1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1;
         end
      end
   end

   // Offers one item and returns at the edge where it is accepted
   task automatic send_item(agent_item_type it);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tdata <= {7'd0, it.rnd_act, it.draw, it.reward, it.nxt_act, it.nxt_vel,
                    it.nxt_alt, it.act, it.cur_vel, it.cur_alt};
      req_tuser <= {it.greedy, it.td_mode, it.kind};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Holds csr_valid high; the caller drops it after its last write
   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Lets every outstanding result drain
   task automatic drain();
      req_tvalid <= 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic load_config(logic [31:0] a, logic [31:0] g, logic [31:0] ei,
                              logic [31:0] ed, logic [31:0] as, logic [31:0] vm,
                              logic [31:0] vs, logic [31:0] mt);
      write_csr(CSR_LEARNING_RATE, a);
      write_csr(CSR_DISCOUNT, g);
      write_csr(CSR_EPSILON_INITIAL, ei);
      write_csr(CSR_EPSILON_DECAY, ed);
      write_csr(CSR_ALTITUDE_SCALE, as);
      write_csr(CSR_VELOCITY_MIN, vm);
      write_csr(CSR_VELOCITY_SCALE, vs);
      write_csr(CSR_MAX_THRUST, mt);
      csr_valid <= 0;
   endtask

   function automatic agent_item_type blank_item(logic [1:0] kind);
      agent_item_type it;
      it = '{kind: kind, default: '0};
      return it;
   endfunction

   // Mostly values near a few buckets so rows get revisited, some full noise
   function automatic logic [31:0] pick_position(logic signed [31:0] origin);
      if ($urandom_range(0, 4) == 0) return $urandom;
      return origin + ($urandom_range(0, 17) << 16) + $urandom_range(0, 65535);
   endfunction

   function automatic agent_item_type random_item();
      agent_item_type it;
      int             k;
      k = $urandom_range(0, 99);
      it.kind = (k < 45) ? KIND_CHOOSE : (k < 85) ? KIND_UPDATE : (k < 95) ? KIND_DECAY
                : KIND_NONE;
      it.cur_alt = pick_position(0);
      it.cur_vel = pick_position(-32'sd655360);
      it.nxt_alt = pick_position(0);
      it.nxt_vel = pick_position(-32'sd655360);
      it.reward = ($urandom_range(0, 2) == 0) ? $urandom
                  : 32'($signed($urandom_range(0, 2097151)) - 1048576);
      it.act = 3'($urandom);
      it.nxt_act = 3'($urandom);
      it.rnd_act = 3'($urandom);
      it.td_mode = 1'($urandom);
      it.greedy = ($urandom_range(0, 3) == 0);
      it.draw = 16'($urandom);
      return it;
   endfunction

   initial begin
      agent_item_type it;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: fast learning so saturation is reachable
      load_config(65535, 65535, 32'(EPS_ONE), 65208, 65536, -655360, 65536, 65535);
      it = blank_item(KIND_CHOOSE);
      it.greedy = 1;
      send_item(it);                        // empty row, tie goes to action 0
      it = blank_item(KIND_CHOOSE);
      it.draw = 16'hFFFF;
      it.rnd_act = 3'd7;
      send_item(it);                        // epsilon one always explores
      repeat (4) begin
         it = blank_item(KIND_UPDATE);
         it.cur_alt = 32'h0001_0000;
         it.act = 3'd3;
         it.nxt_alt = 32'h0001_0000;
         it.reward = 32'h7FFF_FFFF;
         send_item(it);                     // climbs to positive saturation
      end
      it = blank_item(KIND_CHOOSE);
      it.cur_alt = 32'h0001_0000;
      it.greedy = 1;
      send_item(it);                        // greedy picks action 3
      it = blank_item(KIND_UPDATE);
      it.cur_alt = 32'h0005_0000;
      it.reward = 32'h8000_0000;
      it.nxt_alt = 32'h0001_0000;
      it.nxt_act = 3'd3;
      it.td_mode = 1;
      send_item(it);                        // SARSA target from saturated entry
      repeat (3) begin
         it = blank_item(KIND_UPDATE);
         it.cur_alt = 32'h0005_0000;
         it.reward = 32'h8000_0000;
         it.nxt_alt = 32'h0005_0000;
         send_item(it);                     // drives toward negative saturation
      end
      it = blank_item(KIND_UPDATE);
      it.cur_alt = 32'h8000_0000;           // negative altitude counts as zero
      it.cur_vel = 32'h8000_0000;           // below velocity_min
      it.nxt_alt = 32'h7FFF_FFFF;           // clamps to top bucket
      it.nxt_vel = 32'h7FFF_FFFF;
      it.act = 3'd7;
      it.reward = 32'h0000_1234;
      send_item(it);
      it = blank_item(KIND_CHOOSE);
      it.cur_alt = 32'h7FFF_FFFF;
      it.cur_vel = 32'h7FFF_FFFF;
      it.greedy = 1;
      send_item(it);
      repeat (3) send_item(blank_item(KIND_DECAY));
      send_item(blank_item(KIND_NONE));     // unknown kind changes nothing
      it = blank_item(KIND_CHOOSE);
      it.rnd_act = 3'd5;
      send_item(it);                        // draw zero below epsilon
      it = blank_item(KIND_CHOOSE);
      it.draw = 16'hFFFF;
      it.rnd_act = 3'd2;
      send_item(it);                        // draw above decayed epsilon
      drain();

      // Random phases over several register settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: load_config(6554, 64225, 32'(EPS_ONE), 65208, 65536, -655360, 65536, 65535);
            1: load_config(0, 0, 0, 0, 0, 32'h8000_0000, 0, 0);
            2: load_config(65535, 65535, 32'h1FFFF, 65535, 32'hFFFFFF, 32'h7FFF_FFFF,
                           32'hFFFFFF, 65535);
            3: load_config(32768, 49152, 32768, 0, 16384, -655360, 131072, 12345);
            default: load_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65536), $urandom_range(0, 65535),
                                 $urandom_range(16384, 262144), -655360,
                                 $urandom_range(16384, 262144), $urandom_range(0, 65535));
         endcase
         if (p == 1) hold_request = 1;
         if (p == RANDOM_PHASES - 1) quiet = 1;
         repeat (ITEMS_PER_PHASE) send_item(random_item());
         drain();
      end

      repeat (30) @(posedge clock);
      $display("Covered %0d items (%0d table updates) over %0d register settings.",
               sent_count, update_count, RANDOM_PHASES + 1);
      $display("Results seen: %0d, mismatches: %0d.", result_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0 && result_count == sent_count)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
